// File: src/mocd_pkg.sv
// ----------------------------------------------------------------------------
// mocd_pkg
// Shared widths and the ordered mask/match pattern list for the 68000
// opcode class decoder. Position + 1 in the list is the class code.
// ----------------------------------------------------------------------------
package mocd_pkg;

	localparam int WORD_W    = 16;
	localparam int CLASS_W   = 7;
	localparam int PAT_COUNT = 82;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [CLASS_W-1:0] class_t;

	localparam class_t CLASS_UNKNOWN = class_t'(0);

	// order matters: the first pattern that matches wins, quirks included
	localparam word_t PAT_MASK [PAT_COUNT] = '{
		16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
		16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
		16'hfff8, 16'hfff8, 16'hfff8,
		16'hfff0, 16'hfff0,
		16'hffc0, 16'hffc0, 16'hffc0, 16'hffc0, 16'hffc0, 16'hffc0, 16'hffc0,
		16'hffc0, 16'hffc0, 16'hffc0, 16'hffc0, 16'hfe38,
		16'hf0f8, 16'hf1f0, 16'hf1f0, 16'hff80, 16'hff80, 16'hf1c0,
		16'hff00, 16'hff00, 16'hff00, 16'hff00, 16'hff00, 16'hff00, 16'hff00,
		16'hff00, 16'hff00, 16'hff00, 16'hff00, 16'hf0c0, 16'hf130, 16'hf130,
		16'hf0c0, 16'hf130, 16'hf0c0, 16'hf138,
		16'hf1c0, 16'hf1c0, 16'hf1c0, 16'hf1c0, 16'hf1c0, 16'hf1c0, 16'hf1c0,
		16'hf1c0, 16'hf038,
		16'hf018, 16'hf018, 16'hf0c0, 16'hf140, 16'hf018, 16'hf018,
		16'hf100, 16'hf100, 16'hf100, 16'hf000, 16'hf100, 16'hc1c0,
		16'hf000, 16'hf000, 16'hf000, 16'hf000, 16'hf000,
		16'hc000
	};

	localparam word_t PAT_MATCH [PAT_COUNT] = '{
		16'h023c, 16'h027c, 16'h0a3c, 16'h0a7c, 16'h4afc, 16'h4e71, 16'h003c,
		16'h007c, 16'h4e70, 16'h4e73, 16'h4e77, 16'h4e75, 16'h4e72, 16'h4e76,
		16'h4e50, 16'h4840, 16'h4e58,
		16'h4e40, 16'h4e60,
		16'h0800, 16'h0840, 16'h0880, 16'h08c0, 16'h44c0, 16'h40c0, 16'h46c0,
		16'h4840, 16'h4ac0, 16'h4ec0, 16'h4e80, 16'h4800,
		16'h50c8, 16'hc100, 16'h8100, 16'h4880, 16'h4c80, 16'h01c0,
		16'h4200, 16'h0c00, 16'h0a00, 16'h0600, 16'h0200, 16'h0000, 16'h4400,
		16'h4000, 16'h4600, 16'h0400, 16'h4a00, 16'hd0c0, 16'hd100, 16'hc100,
		16'h90c0, 16'h9100, 16'hb0c0, 16'hb108,
		16'h0140, 16'h0180, 16'h0100, 16'h81c0, 16'h80c0, 16'hc1c0, 16'hc0c0,
		16'h41c0, 16'h0008,
		16'he018, 16'he010, 16'h50c0, 16'h4100, 16'he008, 16'he000,
		16'h5000, 16'hb100, 16'h7000, 16'h9000, 16'h5100, 16'h0040,
		16'hd000, 16'hc000, 16'h6000, 16'hb000, 16'h8000,
		16'h0000
	};

endpackage

// File: src/mocd_match.sv
// ----------------------------------------------------------------------------
// mocd_match
// Tests every pattern in parallel and picks the lowest matching position
// with a priority encoder. Purely combinational.
// ----------------------------------------------------------------------------
module mocd_match (
	input  mocd_pkg::word_t  word,
	output mocd_pkg::class_t cls
);
	import mocd_pkg::*;

	logic [PAT_COUNT-1:0] hit;

	always_comb begin
		for (int i = 0; i < PAT_COUNT; i++) begin
			hit[i] = ((word & PAT_MASK[i]) == PAT_MATCH[i]);
		end
	end

	// walk from the back so the earliest hit is left standing
	always_comb begin
		cls = CLASS_UNKNOWN;
		for (int i = PAT_COUNT - 1; i >= 0; i--) begin
			if (hit[i]) begin
				cls = class_t'(i + 1);
			end
		end
	end

endmodule

// File: src/m68k_opcode_class_decoder.sv
// ----------------------------------------------------------------------------
// m68k_opcode_class_decoder
// Classifies a 68000 first opcode word into a dense class code
// (0 unknown, otherwise 1-based index of the first matching pattern).
//
//   channel   valid         stall         payload
//   -------   -----------   -----------   ----------------------
//   input     opcode_valid  opcode_stall  opcode_word [15:0]
//   output    class_valid   class_stall   instr_class [6:0]
//
// Two register stages: opcode word into _s1, class code into _s2.
// One beat per cycle sustained while class_stall is low; the pattern match sits
// between the two registers.
// Reset clears both stage valids; the data registers are not reset.
// A stall on the output only backs up into the input once both stages hold
// a beat.
// ----------------------------------------------------------------------------
module m68k_opcode_class_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               opcode_valid,
	output logic               opcode_stall,
	input  mocd_pkg::word_t    opcode_word,
	output logic               class_valid,
	input  logic               class_stall,
	output mocd_pkg::class_t   instr_class
);
	import mocd_pkg::*;

	logic   vld_s1;
	logic   vld_s2;
	word_t  word_s1;
	class_t cls_s2;
	class_t cls_next;
	logic   load_s2;
	logic   load_s1;

	assign load_s2      = !vld_s2 || !class_stall;
	assign opcode_stall = vld_s1 && !load_s2;
	assign load_s1      = opcode_valid && !opcode_stall;

	mocd_match u_match (
		.word (word_s1),
		.cls  (cls_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load_s2) begin
				vld_s2 <= vld_s1;
			end
			if (load_s1 || load_s2) begin
				vld_s1 <= load_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1 <= opcode_word;
		end
		if (load_s2 && vld_s1) begin
			cls_s2 <= cls_next;
		end
	end

	assign class_valid = vld_s2;
	assign instr_class = cls_s2;

endmodule
